// ===== rtl/tbs_pkg.sv =====
// tbs_pkg: shared constants, types and helper functions of the tag bitmap set.
// No dependencies; used by the interfaces, the map memory and the top level.
package tbs_pkg;

  // geometry of the membership map
  localparam int unsigned MAP_BYTES = 32;
  localparam int unsigned TAG_W     = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BIT_W     = 5;
  localparam int unsigned WSEL_W    = TAG_W - BIT_W;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned EFF_BYTES = (MAP_BYTES < 32) ? MAP_BYTES : 32;
  localparam int unsigned NUM_WORDS = (EFF_BYTES * 8 + WORD_W - 1) / WORD_W;
  localparam int unsigned WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  // fixed limits of the tag space
  localparam logic [TAG_W-1:0]  TAG_MAX   = 8'd255;
  localparam logic [WSEL_W-1:0] LAST_WORD = 3'd7;
  localparam logic [BIT_W-1:0]  LAST_BIT  = 5'd31;
  localparam logic [CNT_W-1:0]  CNT_FULL  = 9'd256;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_DELETE = 3'd1,
    OP_FIND   = 3'd2,
    OP_NEXT   = 3'd3,
    OP_PREV   = 3'd4,
    OP_FIRST  = 3'd5,
    OP_LAST   = 3'd6
  } op_e;

  typedef struct packed {
    logic               en;
    logic [WADDR_W-1:0] addr;
  } tbs_rd_t;

  typedef struct packed {
    logic               en;
    logic [WADDR_W-1:0] addr;
    logic [WORD_W-1:0]  data;
  } tbs_wr_t;

  // index of the lowest set bit, zero when none
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // index of the highest set bit, zero when none
  function automatic logic [BIT_W-1:0] highest_set(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

// ===== rtl/tbs_if.sv =====
// tbs_req_if and tbs_rsp_if: valid/ready channels of the tag bitmap set.
// Depends on tbs_pkg for field widths.
interface tbs_req_if;
  import tbs_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        operation;
  logic [TAG_W-1:0]  tag;
  modport source (output valid, output operation, output tag, input ready);
  modport sink   (input valid, input operation, input tag, output ready);
endinterface

interface tbs_rsp_if;
  import tbs_pkg::*;
  logic              valid;
  logic              ready;
  logic              found;
  logic [TAG_W-1:0]  tag_out;
  logic [CNT_W-1:0]  tag_count;
  modport source (output valid, output found, output tag_out, output tag_count, input ready);
  modport sink   (input valid, input found, input tag_out, input tag_count, output ready);
endinterface

// ===== rtl/tbs_map_mem.sv =====
// tbs_map_mem: word memory of the membership map, registered read.
// Per-row valid bits make unwritten rows read as zero after reset. Uses tbs_pkg.
module tbs_map_mem (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tbs_pkg::tbs_rd_t        rd_i,
  input  tbs_pkg::tbs_wr_t        wr_i,
  output logic [tbs_pkg::WORD_W-1:0] rd_data_o
);
  import tbs_pkg::*;

  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] row_vld_q;
  logic [WORD_W-1:0]    rdata_q;
  logic                 rd_vld_q;

  // storage array and read data register
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  // row valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_i.en) begin
        row_vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_vld_q <= row_vld_q[rd_i.addr];
      end
    end
  end

  assign rd_data_o = rdata_q & {WORD_W{rd_vld_q}};

endmodule

// ===== rtl/tag_bitmap_set_search.sv =====
// tag_bitmap_set_search: 256-tag membership set with add/delete/find/next/prev/first/last.
// Add, delete and find read one map word, then register the result;
// searches read and test one 32-bit map word per cycle unless the result is stalled.
// Throughput: one item at a time; the next input is taken once the result is registered.
// Reset clears the map valid bits and count directly; no clearing sweep.
// Depends on tbs_pkg, tbs_if and tbs_map_mem.
module tag_bitmap_set_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  tbs_req_if.sink     req_i,
  tbs_rsp_if.source   rsp_o
);
  import tbs_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_MOD, ST_SCAN} state_e;

  state_e            state_q;
  op_e               op_q;
  logic [TAG_W-1:0]  tag_q;
  logic [WSEL_W-1:0] cur_q;
  logic [BIT_W-1:0]  bnd_q;
  logic              up_q;
  logic              first_q;
  logic              none_q;
  logic [CNT_W-1:0]  count_q;
  logic              out_vld_q;
  logic              out_found_q;
  logic [TAG_W-1:0]  out_tag_q;
  logic [CNT_W-1:0]  out_cnt_q;

  logic              accept;
  logic              out_free;
  logic              out_load;
  op_e               op_in;
  logic [CNT_W-1:0]  nxt_tag;
  logic [TAG_W-1:0]  prv_tag;
  logic [WSEL_W-1:0] st_cur;
  logic [BIT_W-1:0]  st_bnd;
  logic              st_up;
  logic              st_none;
  logic              st_scan;
  logic [WORD_W-1:0] mem_rdata;
  logic [WORD_W-1:0] word;
  logic              cur_in_rng;
  logic              bit_set;
  logic              in_map;
  logic [WORD_W-1:0] bit_mask;
  logic [CNT_W-1:0]  count_d;
  logic              mod_found;
  logic [WORD_W-1:0] rng_mask;
  logic [WORD_W-1:0] masked;
  logic              hit;
  logic              at_end;
  logic              scan_done;
  logic              scan_adv;
  logic [WSEL_W-1:0] cur_nxt;
  logic [WSEL_W-1:0] rd_word;
  logic [TAG_W-1:0]  hit_tag;
  tbs_rd_t           rd_req;
  tbs_wr_t           wr_req;

  assign op_in    = op_e'(req_i.operation);
  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_vld_q || rsp_o.ready;

  assign req_i.ready     = (state_q == ST_IDLE);
  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.found     = out_found_q;
  assign rsp_o.tag_out   = out_tag_q;
  assign rsp_o.tag_count = out_cnt_q;

  // decode of the start word and bound for an incoming item
  assign nxt_tag = {1'b0, req_i.tag} + CNT_W'(1);
  assign prv_tag = req_i.tag - TAG_W'(1);

  always_comb begin
    st_cur  = req_i.tag[TAG_W-1:BIT_W];
    st_bnd  = req_i.tag[BIT_W-1:0];
    st_up   = 1'b1;
    st_none = 1'b0;
    st_scan = 1'b0;
    unique case (op_in)
      OP_NEXT: begin
        st_cur  = nxt_tag[TAG_W-1:BIT_W];
        st_bnd  = nxt_tag[BIT_W-1:0];
        st_none = nxt_tag[TAG_W];
        st_scan = 1'b1;
      end
      OP_PREV: begin
        st_cur  = prv_tag[TAG_W-1:BIT_W];
        st_bnd  = prv_tag[BIT_W-1:0];
        st_up   = 1'b0;
        st_none = (req_i.tag == '0);
        st_scan = 1'b1;
      end
      OP_FIRST: begin
        st_cur  = '0;
        st_bnd  = '0;
        st_scan = 1'b1;
      end
      OP_LAST: begin
        st_cur  = LAST_WORD;
        st_bnd  = LAST_BIT;
        st_up   = 1'b0;
        st_scan = 1'b1;
      end
      default: begin
        st_scan = 1'b0;
      end
    endcase
  end

  // current word, zero where the map has no storage
  assign cur_in_rng = {1'b0, cur_q} < (WSEL_W + 1)'(NUM_WORDS);
  assign word       = mem_rdata & {WORD_W{cur_in_rng}};

  // read-modify-write of one bit
  assign bit_set  = word[tag_q[BIT_W-1:0]];
  assign in_map   = {3'b000, tag_q[TAG_W-1:3]} < TAG_W'(MAP_BYTES);
  assign bit_mask = WORD_W'(1) << tag_q[BIT_W-1:0];

  always_comb begin
    count_d     = count_q;
    mod_found   = 1'b0;
    wr_req.en   = 1'b0;
    wr_req.addr = cur_q[WADDR_W-1:0];
    wr_req.data = word;
    unique case (op_q)
      OP_ADD: begin
        mod_found = bit_set;
        if (in_map && !bit_set) begin
          wr_req.en   = (state_q == ST_MOD) && out_free;
          wr_req.data = word | bit_mask;
          if (count_q < CNT_FULL) count_d = count_q + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        mod_found = bit_set;
        if (bit_set) begin
          wr_req.en   = (state_q == ST_MOD) && out_free;
          wr_req.data = word & ~bit_mask;
          if (count_q != '0) count_d = count_q - CNT_W'(1);
        end
      end
      OP_FIND: begin
        mod_found = bit_set;
      end
      default: begin
        mod_found = 1'b0;
      end
    endcase
  end

  // scan step over one word
  always_comb begin
    rng_mask = '1;
    if (first_q) begin
      rng_mask = up_q ? ({WORD_W{1'b1}} << bnd_q) : ({WORD_W{1'b1}} >> (LAST_BIT - bnd_q));
    end
  end

  assign masked    = word & rng_mask;
  assign hit       = (|masked) && !none_q;
  assign at_end    = up_q ? (cur_q == LAST_WORD) : (cur_q == '0);
  assign scan_done = hit || at_end || none_q;
  assign scan_adv  = (state_q == ST_SCAN) && out_free && !scan_done;
  assign cur_nxt   = up_q ? (cur_q + WSEL_W'(1)) : (cur_q - WSEL_W'(1));
  assign hit_tag   = {cur_q, (up_q ? lowest_set(masked) : highest_set(masked))};

  // a result is registered when the current item completes
  assign out_load = out_free &&
                    ((state_q == ST_MOD) || ((state_q == ST_SCAN) && scan_done));

  // map word read port
  assign rd_word     = accept ? st_cur : cur_nxt;
  assign rd_req.en   = (accept || scan_adv) && ({1'b0, rd_word} < (WSEL_W + 1)'(NUM_WORDS));
  assign rd_req.addr = rd_word[WADDR_W-1:0];

  tbs_map_mem u_map_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (rd_req),
    .wr_i      (wr_req),
    .rd_data_o (mem_rdata)
  );

  // control state machine and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_ADD;
      tag_q       <= '0;
      cur_q       <= '0;
      bnd_q       <= '0;
      up_q        <= 1'b1;
      first_q     <= 1'b0;
      none_q      <= 1'b0;
      count_q     <= '0;
      out_vld_q   <= 1'b0;
      out_found_q <= 1'b0;
      out_tag_q   <= '0;
      out_cnt_q   <= '0;
    end else begin
      // result valid: set on a new result, cleared on a transfer
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q    <= op_in;
            tag_q   <= req_i.tag;
            cur_q   <= st_cur;
            bnd_q   <= st_bnd;
            up_q    <= st_up;
            none_q  <= st_none;
            first_q <= 1'b1;
            state_q <= st_scan ? ST_SCAN : ST_MOD;
          end
        end
        ST_MOD: begin
          if (out_free) begin
            count_q     <= count_d;
            out_found_q <= mod_found;
            out_tag_q   <= tag_q;
            out_cnt_q   <= count_d;
            state_q     <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (out_free) begin
            if (scan_done) begin
              out_found_q <= hit;
              out_tag_q   <= hit ? hit_tag : '0;
              out_cnt_q   <= count_q;
              state_q     <= ST_IDLE;
            end else begin
              cur_q   <= cur_nxt;
              first_q <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/tbs_checker.sv =====
// tbs_checker: port-level assertions for tag_bitmap_set_search, bound to the top level.
// Depends on tbs_pkg for field widths.
module tbs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic [tbs_pkg::CNT_W-1:0]   rsp_tag_count_i
);
  import tbs_pkg::*;

  // a waiting result stays offered
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped before transfer");

  // a waiting result keeps its count
  a_rsp_cnt_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_tag_count_i))
    else $error("result count changed while stalled");

  // count never exceeds the tag space
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_tag_count_i <= CNT_FULL)
    else $error("tag count out of range");

  // one item in flight: input closes after a transfer
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("second item accepted while busy");

endmodule

bind tag_bitmap_set_search tbs_checker u_tbs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_tag_count_i (rsp_o.tag_count)
);

// ===== verif/tag_bitmap_set_search_tb.sv =====
// tag_bitmap_set_search_tb: self-checking testbench for the tag bitmap set block.
// Directed and random add/delete/find/search transfers are checked against a scoreboard
// that keeps its own 256-bit membership map. Depends on tbs_pkg, tbs_if and the RTL.
module tag_bitmap_set_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbs_pkg::*;

  localparam logic [2:0]  OP_UNUSED   = 3'd7;
  localparam int unsigned IDLE_PCT    = 17;
  localparam int unsigned ITEM_GOAL   = 1450;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 16;

  typedef struct {
    logic             found;
    logic [TAG_W-1:0] tag_out;
    logic [CNT_W-1:0] tag_count;
  } tag_result_t;

  // scoreboard: own copy of the membership map, expected results in order
  class tag_set_scoreboard;
    bit [255:0]    members;
    int unsigned   population;
    tag_result_t   expected_q[$];
    int unsigned   errors;

    // nearest member walking from 'from' in direction 'dir', both ends inclusive
    function logic nearest(int from, int dir, output logic [TAG_W-1:0] hit);
      hit = '0;
      for (int t = from; t >= 0 && t <= 255; t += dir) begin
        if (members[t]) begin
          hit = TAG_W'(t);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(logic [2:0] op, logic [TAG_W-1:0] tag);
      tag_result_t res;
      logic        in_map;
      logic        present;
      in_map      = (int'(tag) >> 3) < int'(MAP_BYTES);
      present     = in_map && members[tag];
      res.found   = 1'b0;
      res.tag_out = tag;
      case (op)
        OP_ADD: begin
          res.found = present;
          if (in_map && !present) begin
            members[tag] = 1'b1;
            population++;
          end
        end
        OP_DELETE: begin
          res.found = present;
          if (in_map && present) begin
            members[tag] = 1'b0;
            population--;
          end
        end
        OP_FIND:  res.found = present;
        OP_NEXT:  res.found = nearest(int'(tag) + 1, 1, res.tag_out);
        OP_PREV:  res.found = nearest(int'(tag) - 1, -1, res.tag_out);
        OP_FIRST: res.found = nearest(0, 1, res.tag_out);
        OP_LAST:  res.found = nearest(255, -1, res.tag_out);
        default:  res.found = 1'b0;
      endcase
      res.tag_count = CNT_W'(population);
      expected_q.push_back(res);
    endfunction

    function void check_response(logic found, logic [TAG_W-1:0] tag_out,
                                 logic [CNT_W-1:0] tag_count);
      tag_result_t exp;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: found %0d tag_out %0d tag_count %0d",
               found, tag_out, tag_count);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (found !== exp.found) begin
        $error("found: expected %0d, actual %0d", exp.found, found);
        errors++;
      end
      if (tag_out !== exp.tag_out) begin
        $error("tag_out: expected %0d, actual %0d", exp.tag_out, tag_out);
        errors++;
      end
      if (tag_count !== exp.tag_count) begin
        $error("tag_count: expected %0d, actual %0d", exp.tag_count, tag_count);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tbs_req_if req_if ();
  tbs_rsp_if rsp_if ();

  tag_bitmap_set_search dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  tag_set_scoreboard sb;
  bit                quiet;
  int unsigned       items_sent;
  int unsigned       cycle_count = 0;
  logic [TAG_W-1:0]  hot_base;
  logic [TAG_W-1:0]  tag_order [256];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random back-pressure, changed at the falling edge
  always @(negedge clk_i) begin
    rsp_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // result side: check each transfer
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      sb.check_response(rsp_if.found, rsp_if.tag_out, rsp_if.tag_count);
  end

  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // one request transfer, with random idle cycles ahead of it
  task automatic send_item(input logic [2:0] op, input logic [TAG_W-1:0] tag);
    while (idle_now()) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.tag       <= tag;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(op, tag);
    items_sent++;
  endtask

  function automatic logic [TAG_W-1:0] pick_tag();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8)
      return (r % 2 == 1) ? TAG_MAX : '0;
    if (r < 30)
      return hot_base + TAG_W'($urandom_range(15));
    return TAG_W'($urandom);
  endfunction

  function automatic logic [2:0] pick_search();
    case ($urandom_range(4))
      0:       return OP_FIND;
      1:       return OP_NEXT;
      2:       return OP_PREV;
      3:       return OP_FIRST;
      default: return OP_LAST;
    endcase
  endfunction

  function automatic logic [2:0] pick_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 28) return OP_ADD;
    if (r < 46) return OP_DELETE;
    if (r < 56) return OP_FIND;
    if (r < 70) return OP_NEXT;
    if (r < 84) return OP_PREV;
    if (r < 91) return OP_FIRST;
    if (r < 98) return OP_LAST;
    return OP_UNUSED;
  endfunction

  // random permutation of all tag values
  function automatic void shuffle_tag_order();
    logic [TAG_W-1:0] swap;
    int unsigned      j;
    for (int i = 0; i < 256; i++) tag_order[i] = TAG_W'(i);
    for (int i = 255; i > 0; i--) begin
      j            = $urandom_range(i);
      swap         = tag_order[i];
      tag_order[i] = tag_order[j];
      tag_order[j] = swap;
    end
  endfunction

  task automatic mixed_phase(input int unsigned count);
    hot_base = TAG_W'($urandom);
    repeat (count) send_item(pick_op(), pick_tag());
  endtask

  // add or delete every tag in random order, searches mixed in
  task automatic sweep_phase(input logic [2:0] op);
    shuffle_tag_order();
    for (int i = 0; i < 256; i++) begin
      send_item(op, tag_order[i]);
      if ($urandom_range(3) == 0) send_item(pick_search(), pick_tag());
    end
  endtask

  initial begin
    sb           = new();
    quiet        = 1'b0;
    items_sent   = 0;
    hot_base     = '0;
    rst_ni       = 1'b0;
    req_if.valid     = 1'b0;
    req_if.operation = OP_ADD;
    req_if.tag       = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // searches and a delete on the empty map
    send_item(OP_FIRST, 8'd0);
    send_item(OP_LAST, 8'd0);
    send_item(OP_NEXT, 8'd0);
    send_item(OP_PREV, TAG_MAX);
    send_item(OP_DELETE, 8'd0);
    // extremes, duplicate add, edge searches
    send_item(OP_ADD, 8'd0);
    send_item(OP_ADD, TAG_MAX);
    send_item(OP_ADD, 8'd0);
    send_item(OP_FIND, 8'd0);
    send_item(OP_FIND, 8'd1);
    send_item(OP_FIND, TAG_MAX);
    send_item(OP_NEXT, TAG_MAX);
    send_item(OP_PREV, 8'd0);
    send_item(OP_NEXT, 8'd0);
    send_item(OP_PREV, TAG_MAX);
    send_item(OP_ADD, 8'd128);
    send_item(OP_NEXT, 8'd0);
    send_item(OP_PREV, TAG_MAX);
    send_item(OP_FIRST, 8'd77);
    send_item(OP_LAST, 8'd77);
    // absent delete, real delete, repeated delete, unused code
    send_item(OP_DELETE, 8'd1);
    send_item(OP_DELETE, 8'd0);
    send_item(OP_DELETE, 8'd0);
    send_item(OP_UNUSED, 8'hAA);
    send_item(OP_UNUSED, 8'h55);

    // random part: mix, fill to a full map, work on it, drain to empty, mix to the item goal
    mixed_phase(200);
    sweep_phase(OP_ADD);
    quiet = 1'b1;
    mixed_phase(250);
    quiet = 1'b0;
    sweep_phase(OP_DELETE);
    while (items_sent < ITEM_GOAL) mixed_phase(50);

    @(negedge clk_i);
    req_if.valid <= 1'b0;

    // wait for outstanding results, then keep watching for strays
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
